// ----- rtl/wtli_pkg.sv -----
// ----------------------------------------------------------------------------
// wtli_pkg
// Shared types and constants for the interpolating wavetable reader.
// ----------------------------------------------------------------------------
package wtli_pkg;

   localparam int WAVE_DEPTH       = 2048;
   localparam int SAMPLE_BITS      = 16;
   localparam int PHASE_BITS       = 32;
   localparam int ENTRY_INDEX_BITS = 11;

   localparam int IDX_BITS  = $clog2(WAVE_DEPTH);
   localparam int FRAC_BITS = PHASE_BITS - IDX_BITS;
   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0]      sample_type;
   typedef logic        [IDX_BITS-1:0]         index_type;
   typedef logic        [ENTRY_INDEX_BITS-1:0] entry_index_type;
   typedef logic        [PHASE_BITS-1:0]       phase_type;
   typedef logic        [FRAC_BITS-1:0]        frac_type;
   typedef logic signed [DIFF_BITS-1:0]        diff_type;
   typedef logic signed [PROD_BITS-1:0]        prod_type;

endpackage

// ----- rtl/wtli_if.sv -----
// ----------------------------------------------------------------------------
// wtli_req_if / wtli_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface wtli_req_if;
   import wtli_pkg::*;

   logic            valid;
   logic            ready;
   logic            mode;
   entry_index_type entry_index;
   sample_type      entry_value;
   phase_type       phase;

   modport source (output valid, mode, entry_index, entry_value, phase, input ready);
   modport sink   (input valid, mode, entry_index, entry_value, phase, output ready);
endinterface

interface wtli_rsp_if;
   import wtli_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

// ----- rtl/wtli_ram.sv -----
// ----------------------------------------------------------------------------
// wtli_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module wtli_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

// ----- rtl/wavetable_linear_interp_read.sv -----
// ----------------------------------------------------------------------------
// wavetable_linear_interp_read
// Wavetable lookup with linear interpolation between adjacent entries.
//
//   channel  dir  payload                                  notes
//   req      in   mode, entry_index, entry_value, phase    write or read
//   rsp      out  sample                                   one per read
//
// One transaction per cycle while req.ready is high, writes and reads mixed freely.
// A read's two adjacent entries are read on the RAM's two read ports at its
// accepting edge, then difference, multiply, add. A write gives no
// response and is visible to the next read.
// Reset clears only the pipeline valids; table contents stay undefined.
// A stalled rsp fills the stages and then drops req.ready.
// ----------------------------------------------------------------------------
module wavetable_linear_interp_read (
   input logic clock,
   input logic reset,
   wtli_req_if.sink   req,
   wtli_rsp_if.source rsp
);
   import wtli_pkg::*;

   logic       s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic       s1_v_in, s2_v_in, s3_v_in, out_v_in;
   logic       s1_go, s2_go, s3_go;
   logic       s1_free, s2_free, s3_free, out_free;
   logic       rd_accept, wr_accept;

   index_type  idx_a, idx_b;
   sample_type ram_a, ram_b;
   frac_type   f_s1_ff, f_s2_ff;
   sample_type a_s2_ff, a_s3_ff;
   diff_type   d_s2_ff;
   prod_type   prod_s3_ff;
   diff_type   q_c, sum_c;
   sample_type sample_ff;

   // handshake chain
   assign out_free = !out_v_ff || rsp.ready;
   assign s3_go    = s3_v_ff && out_free;
   assign s3_free  = !s3_v_ff || s3_go;
   assign s2_go    = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s2_go;
   assign s1_go    = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s1_go;

   assign req.ready = s1_free;
   assign rd_accept = req.valid && req.ready && (req.mode == MODE_READ);
   assign wr_accept = req.valid && req.ready && (req.mode == MODE_WRITE);

   assign idx_a = req.phase[PHASE_BITS-1 -: IDX_BITS];
   assign idx_b = index_type'(idx_a + 1'b1);

   wtli_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WAVE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_accept),
      .wr_addr   (req.entry_index[IDX_BITS-1:0]),
      .wr_data   (req.entry_value),
      .rd_en     (rd_accept),
      .rd_addr_a (idx_a),
      .rd_addr_b (idx_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   assign s1_v_in  = (s1_v_ff && !s1_go) || rd_accept;
   assign s2_v_in  = (s2_v_ff && !s2_go) || s1_go;
   assign s3_v_in  = (s3_v_ff && !s3_go) || s2_go;
   assign out_v_in = (out_v_ff && !rsp.ready) || s3_go;

   // floor((b - a) * f) is an arithmetic shift of the signed product
   assign q_c   = diff_type'(prod_s3_ff >>> FRAC_BITS);
   assign sum_c = diff_type'(a_s3_ff) + q_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
      end
      if (rd_accept) begin
         f_s1_ff <= req.phase[FRAC_BITS-1:0];
      end
      if (s1_go) begin
         a_s2_ff <= ram_a;
         d_s2_ff <= diff_type'(ram_b) - diff_type'(ram_a);
         f_s2_ff <= f_s1_ff;
      end
      if (s2_go) begin
         a_s3_ff    <= a_s2_ff;
         prod_s3_ff <= d_s2_ff * $signed({1'b0, f_s2_ff});
      end
      if (s3_go) begin
         sample_ff <= sum_c[SAMPLE_BITS-1:0];
      end
   end

   assign rsp.valid  = out_v_ff;
   assign rsp.sample = sample_ff;

   a_s1_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_v_ff) |-> $past(req.valid && req.ready && (req.mode == MODE_READ)))
      else $error("stage 1 filled without a read transaction");

   a_write_no_entry: assert property (@(posedge clock) disable iff (reset)
      wr_accept |=> !s1_v_ff)
      else $error("write transaction entered the read pipeline");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff && !rsp.ready) |-> !req.ready)
      else $error("request accepted with a full, stalled pipeline");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !s2_go) |=> (s2_v_ff && $stable(d_s2_ff) && $stable(a_s2_ff)))
      else $error("stage 2 lost data while stalled");

endmodule
